FILE: rtl/pqx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqx_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int OP_W      = 2;
	localparam int VAL_W     = 16;
	localparam int PRI_W     = 8;
	localparam int CNT_OUT_W = 6;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	// per-cell control, broadcast from the sequencer
	typedef struct packed {
		logic occ;    // cell holds a live entry
		logic wr;     // load the incoming pair
		logic shift;  // take the neighbour's entry
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pqx_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pqx_cell #(
	parameter int DEPTH = pqx_pkg::DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int IW   = $clog2(DEPTH)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  pqx_pkg::cell_ctl_t            ctl,
	input  wire  [pqx_pkg::VAL_W-1:0]     wr_value,
	input  wire  [pqx_pkg::PRI_W-1:0]     wr_priority,
	input  wire  [pqx_pkg::VAL_W-1:0]     nxt_value,
	input  wire  [pqx_pkg::PRI_W-1:0]     nxt_priority,
	input  wire                           cin_valid,
	input  wire  [pqx_pkg::PRI_W-1:0]     cin_priority,
	input  wire  [pqx_pkg::VAL_W-1:0]     cin_value,
	input  wire  [IW-1:0]                 cin_idx,
	output logic                          cout_valid,
	output logic [pqx_pkg::PRI_W-1:0]     cout_priority,
	output logic [pqx_pkg::VAL_W-1:0]     cout_value,
	output logic [IW-1:0]                 cout_idx,
	output logic [pqx_pkg::VAL_W-1:0]     value,
	output logic [pqx_pkg::PRI_W-1:0]     priority_q
);

	logic [pqx_pkg::VAL_W-1:0] value_q;
	logic                      take_own;

	assign value = value_q;

	// strictly greater: an earlier cell keeps the win on a tie
	assign take_own = ctl.occ && (!cin_valid || (priority_q > cin_priority));

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			value_q    <= wr_value;
			priority_q <= wr_priority;
		end else if (ctl.shift) begin
			value_q    <= nxt_value;
			priority_q <= nxt_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout_valid <= 1'b0;
		end else begin
			cout_valid <= take_own || cin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			cout_priority <= priority_q;
			cout_value    <= value_q;
			cout_idx      <= IW'(IDX);
		end else begin
			cout_priority <= cin_priority;
			cout_value    <= cin_value;
			cout_idx      <= cin_idx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/priority_queue_extract_max.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake            | Word
// --------+----------------------+-----------------------------------------------------
// input   | in_valid / in_ready  | op, item_value, item_priority
// output  | res_valid / res_ready| out_value, out_valid, dropped, entry_count,
//         |                      | is_empty, is_full
//
// Insert, clear and the unused op code are accepted, then handed over to the output
// register. Extract is accepted, then the running maximum ripples one cell per cycle
// down the chain of DEPTH cells; the shift state then closes the gap, the done state
// hands the word over. An extract on an empty queue skips the scan and the shift.
// Reset empties the queue; the entry registers are not cleared, only the fill count.
// The output register holds a word while res_ready is low; the next word may be accepted
// meanwhile and waits in the pending stage until the output register frees.

module priority_queue_extract_max #(
	parameter int DEPTH = pqx_pkg::DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [pqx_pkg::OP_W-1:0]         op,
	input  wire  [pqx_pkg::VAL_W-1:0]        item_value,
	input  wire  [pqx_pkg::PRI_W-1:0]        item_priority,
	output logic                             res_valid,
	input  wire                              res_ready,
	output logic [pqx_pkg::VAL_W-1:0]        out_value,
	output logic                             out_valid,
	output logic                             dropped,
	output logic [pqx_pkg::CNT_OUT_W-1:0]    entry_count,
	output logic                             is_empty,
	output logic                             is_full
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q;
	logic [IW-1:0]               scan_q;

	// pending word, waiting for the output register
	logic [pqx_pkg::VAL_W-1:0]   pnd_value_q;
	logic                        pnd_valid_q;
	logic                        pnd_dropped_q;

	logic                        accept;
	logic                        out_free;
	logic                        do_insert;
	logic                        do_shift;
	pqx_pkg::op_t                op_in;

	// cell chain wiring
	pqx_pkg::cell_ctl_t          ctl   [DEPTH];
	logic [pqx_pkg::VAL_W-1:0]   val_a [DEPTH];
	logic [pqx_pkg::PRI_W-1:0]   pri_a [DEPTH];
	logic                        cv    [DEPTH+1];
	logic [pqx_pkg::PRI_W-1:0]   cp    [DEPTH+1];
	logic [pqx_pkg::VAL_W-1:0]   cval  [DEPTH+1];
	logic [IW-1:0]               cidx  [DEPTH+1];

	assign op_in     = pqx_pkg::op_t'(op);
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !res_valid || res_ready;
	assign do_insert = accept && (op_in == pqx_pkg::OP_INSERT) && (count_q < CW'(DEPTH));
	assign do_shift  = (state_q == S_SHIFT);

	// head of the chain: no candidate yet
	assign cv[0]   = 1'b0;
	assign cp[0]   = '0;
	assign cval[0] = '0;
	assign cidx[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [pqx_pkg::VAL_W-1:0] nv;
		logic [pqx_pkg::PRI_W-1:0] np;

		// last cell keeps its own entry on a shift; it lies beyond the new count anyway
		if (i == DEPTH - 1) begin : g_tail
			assign nv = val_a[i];
			assign np = pri_a[i];
		end else begin : g_body
			assign nv = val_a[i+1];
			assign np = pri_a[i+1];
		end

		assign ctl[i].occ   = (CW'(i) < count_q);
		assign ctl[i].wr    = do_insert && (CW'(i) == count_q);
		assign ctl[i].shift = do_shift && (IW'(i) >= cidx[DEPTH]);

		pqx_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl[i]),
			.wr_value      (item_value),
			.wr_priority   (item_priority),
			.nxt_value     (nv),
			.nxt_priority  (np),
			.cin_valid     (cv[i]),
			.cin_priority  (cp[i]),
			.cin_value     (cval[i]),
			.cin_idx       (cidx[i]),
			.cout_valid    (cv[i+1]),
			.cout_priority (cp[i+1]),
			.cout_value    (cval[i+1]),
			.cout_idx      (cidx[i+1]),
			.value         (val_a[i]),
			.priority_q    (pri_a[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			scan_q        <= '0;
			pnd_value_q   <= '0;
			pnd_valid_q   <= 1'b0;
			pnd_dropped_q <= 1'b0;
			res_valid     <= 1'b0;
			out_value     <= '0;
			out_valid     <= 1'b0;
			dropped       <= 1'b0;
			entry_count   <= '0;
			is_empty      <= 1'b1;
			is_full       <= 1'b0;
		end else begin
			// drop the output word once taken, unless the next word loads in its place
			if (res_valid && res_ready && (state_q != S_DONE)) begin
				res_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pnd_value_q   <= '0;
						pnd_valid_q   <= 1'b0;
						pnd_dropped_q <= 1'b0;
						scan_q        <= '0;
						state_q       <= S_DONE;
						case (op_in)
							pqx_pkg::OP_INSERT: begin
								if (count_q < CW'(DEPTH)) begin
									count_q <= count_q + 1'b1;
								end else begin
									pnd_dropped_q <= 1'b1;
								end
							end
							pqx_pkg::OP_EXTRACT: begin
								if (count_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							pqx_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// advance until the maximum has rippled past the last cell
					scan_q <= scan_q + 1'b1;
					if (scan_q == IW'(DEPTH - 1)) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					pnd_value_q <= cval[DEPTH];
					pnd_valid_q <= 1'b1;
					count_q     <= count_q - 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						res_valid   <= 1'b1;
						out_value   <= pnd_value_q;
						out_valid   <= pnd_valid_q;
						dropped     <= pnd_dropped_q;
						entry_count <= pqx_pkg::CNT_OUT_W'(count_q);
						is_empty    <= (count_q == '0);
						is_full     <= (count_q == CW'(DEPTH));
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// the fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond capacity");

	// an insert with room grows the queue by exactly one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not advance the fill count");

	// the maximum found at the end of a scan is a live entry
	a_scan_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (cv[DEPTH] && (CW'(cidx[DEPTH]) < count_q)))
		else $error("extract scan found no live entry");

	// a word never reports both an extracted value and a dropped insert
	a_word_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && dropped))
		else $error("output word flags both extract and drop");
`endif

endmodule

`default_nettype wire

FILE: tb/priority_queue_extract_max_test.sv
`timescale 1ns / 1ps

module priority_queue_extract_max_test;

	import pqx_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// op code three has no meaning in the queue: it reports status and changes nothing
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Allow for the longest operation (an extract ripples through every cell) plus slack.
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

	// Number of random words to push after the directed script.
	localparam int RANDOM_WORDS = 500;

	// One result word as the block reports it.
	typedef struct packed {
		logic [VAL_W-1:0]     value;
		logic                 valid;
		logic                 dropped;
		logic [CNT_OUT_W-1:0] count;
		logic                 empty;
		logic                 full;
	} pq_result_t;

	// One row of the directed script. Where 'typed' is set, 'want' is taken as it stands;
	// otherwise the expected word comes from the queue model below.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [PRI_W-1:0] prio;
		logic             typed;
		pq_result_t       want;
	} script_row_t;

	// Status of an empty queue after an operation that moved nothing out.
	localparam pq_result_t IDLE_EMPTY = '{16'h0000, 1'b0, 1'b0, 6'd0, 1'b1, 1'b0};
	localparam pq_result_t UNTYPED    = '0;

	localparam int SCRIPT_LEN = 23;

	// Directed script: an empty queue first, then both priority extremes with a tie at
	// each end, the unused op code with the queue holding entries, a drain back to empty,
	// a clear with entries held and an extract straight after it.
	localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b1, IDLE_EMPTY},
		'{OP_UNUSED,  16'hFFFF, 8'hFF, 1'b1, IDLE_EMPTY},
		'{OP_CLEAR,   16'hFFFF, 8'hFF, 1'b1, IDLE_EMPTY},
		'{OP_INSERT,  16'hFFFF, 8'hFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 6'd1, 1'b0, 1'b0}},
		'{OP_INSERT,  16'h0000, 8'h00, 1'b1, '{16'h0000, 1'b0, 1'b0, 6'd2, 1'b0, 1'b0}},
		'{OP_INSERT,  16'h1234, 8'hFF, 1'b0, UNTYPED},
		'{OP_INSERT,  16'hAAAA, 8'h55, 1'b0, UNTYPED},
		'{OP_INSERT,  16'h5555, 8'hAA, 1'b0, UNTYPED},
		'{OP_UNUSED,  16'h0F0F, 8'h0F, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'hFFFF, 8'hFF, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b0, UNTYPED},
		'{OP_INSERT,  16'h0001, 8'h00, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b0, UNTYPED},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b1, IDLE_EMPTY},
		'{OP_INSERT,  16'h00FF, 8'h80, 1'b0, UNTYPED},
		'{OP_INSERT,  16'hFF00, 8'h7F, 1'b0, UNTYPED},
		'{OP_CLEAR,   16'h0000, 8'h00, 1'b1, IDLE_EMPTY},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b1, IDLE_EMPTY},
		'{OP_INSERT,  16'h8000, 8'h01, 1'b1, '{16'h0000, 1'b0, 1'b0, 6'd1, 1'b0, 1'b0}},
		'{OP_EXTRACT, 16'h0000, 8'h00, 1'b1, '{16'h8000, 1'b1, 1'b0, 6'd0, 1'b1, 1'b0}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [OP_W-1:0]      op;
	logic [VAL_W-1:0]     item_value;
	logic [PRI_W-1:0]     item_priority;
	logic                 res_valid;
	logic                 res_ready;
	logic [VAL_W-1:0]     out_value;
	logic                 out_valid;
	logic                 dropped;
	logic [CNT_OUT_W-1:0] entry_count;
	logic                 is_empty;
	logic                 is_full;

	// Model of the queue: entries in arrival order, and how many are held.
	logic [VAL_W-1:0] held_value [DEPTH];
	logic [PRI_W-1:0] held_prio  [DEPTH];
	int               held_count;

	pq_result_t expected_words [$];
	int         mismatches;
	// Random idling on both channels; cleared for one long quiet stretch.
	bit         stall_en;

	priority_queue_extract_max #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.item_value   (item_value),
		.item_priority(item_priority),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_value    (out_value),
		.out_valid    (out_valid),
		.dropped      (dropped),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	// 10 ns clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the queue model and return the word it should produce.
	// Extract takes the first entry of the highest priority, so a tie goes to the
	// earliest arrival; the entries behind it move up one place.
	function automatic pq_result_t apply_op(input logic [OP_W-1:0] o,
			input logic [VAL_W-1:0] v, input logic [PRI_W-1:0] p);
		pq_result_t r;
		int         best;
		r = '0;
		case (o)
			OP_INSERT: begin
				if (held_count < DEPTH) begin
					held_value[held_count] = v;
					held_prio[held_count]  = p;
					held_count++;
				end else begin
					r.dropped = 1'b1;
				end
			end
			OP_EXTRACT: begin
				if (held_count > 0) begin
					best = 0;
					for (int k = 1; k < held_count; k++)
						if (held_prio[k] > held_prio[best])
							best = k;
					r.value = held_value[best];
					r.valid = 1'b1;
					for (int k = best; k + 1 < held_count; k++) begin
						held_value[k] = held_value[k + 1];
						held_prio[k]  = held_prio[k + 1];
					end
					held_count--;
				end
			end
			OP_CLEAR: begin
				held_count = 0;
			end
			default: ;
		endcase
		r.count = held_count[CNT_OUT_W-1:0];
		r.empty = (held_count == 0);
		r.full  = (held_count == DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Offer one word on the input channel and hold it until accepted. Entered and left
	// at a falling edge, so valid stays high without a drop when words follow back to back.
	task automatic push_word(input logic [OP_W-1:0] o, input logic [VAL_W-1:0] v,
			input logic [PRI_W-1:0] p, input logic typed, input pq_result_t want);
		pq_result_t predicted;
		while (stall_en && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		op            <= o;
		item_value    <= v;
		item_priority <= p;
		do
			@(posedge clk);
		while (!in_ready);
		// Accepted at this edge: advance the model in step with the block.
		predicted = apply_op(o, v, p);
		expected_words.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Random words in bursts of one character each: filling bursts drive the queue to full
	// and into dropped inserts, draining bursts empty it, mixed bursts wander in between.
	// Half the bursts draw priorities from a tiny range so that ties are common.
	task automatic run_random(input int n_words);
		int               sent;
		int               burst_left;
		int               mode;
		int               pick;
		int               ins_pct;
		int               ext_pct;
		bit               narrow;
		logic [OP_W-1:0]  o;
		logic [VAL_W-1:0] v;
		logic [PRI_W-1:0] p;
		sent       = 0;
		burst_left = 0;
		mode       = 0;
		narrow     = 1'b0;
		while (sent < n_words) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 60);
				mode       = $urandom_range(0, 2);
				narrow     = $urandom_range(0, 1);
			end
			burst_left--;
			// hold idling off for one long stretch in the middle of the run
			stall_en = !(sent >= 200 && sent < 320);
			case (mode)
				0:       begin ins_pct = 80; ext_pct = 94; end
				1:       begin ins_pct = 15; ext_pct = 96; end
				default: begin ins_pct = 48; ext_pct = 94; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < ins_pct)
				o = OP_INSERT;
			else if (pick < ext_pct)
				o = OP_EXTRACT;
			else if (pick < ext_pct + 2)
				o = OP_CLEAR;
			else
				o = OP_UNUSED;
			v = $urandom;
			if ($urandom_range(0, 9) == 0)
				p = $urandom_range(0, 1) ? '1 : '0;
			else if (narrow)
				p = $urandom_range(0, 3);
			else
				p = $urandom_range(0, 255);
			push_word(o, v, p, 1'b0, UNTYPED);
			// the unused op code changes nothing in the queue, so leave it out of the tally
			if (o != OP_UNUSED)
				sent++;
		end
		stall_en = 1'b1;
	endtask

	// Output side: stall at random on the falling edge, one assignment per edge.
	always @(negedge clk) begin
		res_ready <= !stall_en || ($urandom_range(0, 99) >= 6);
	end

	// Check every accepted result word against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("result word with nothing expected, out_value", out_value, 0);
			end else begin
				automatic pq_result_t want = expected_words.pop_front();
				if (out_value !== want.value)
					report_mismatch("out_value", out_value, want.value);
				if (out_valid !== want.valid)
					report_mismatch("out_valid", out_valid, want.valid);
				if (dropped !== want.dropped)
					report_mismatch("dropped", dropped, want.dropped);
				if (entry_count !== want.count)
					report_mismatch("entry_count", entry_count, want.count);
				if (is_empty !== want.empty)
					report_mismatch("is_empty", is_empty, want.empty);
				if (is_full !== want.full)
					report_mismatch("is_full", is_full, want.full);
			end
		end
	end

	// Main sequence: reset, directed script, random bursts, drain, verdict.
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_INSERT;
		item_value    = '0;
		item_priority = '0;
		res_ready     = 1'b0;
		held_count    = 0;
		mismatches    = 0;
		stall_en      = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < SCRIPT_LEN; r++)
			push_word(SCRIPT[r].op, SCRIPT[r].value, SCRIPT[r].prio, SCRIPT[r].typed,
				SCRIPT[r].want);

		run_random(RANDOM_WORDS);
		in_valid <= 1'b0;

		// Wait for every expected word, then watch a while longer for strays.
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_words.size() != 0 || mismatches != 0)
			$display("FAILURE");
		else
			$display("SUCCESS");
		$finish;
	end

	// Watchdog: the slowest correct run needs well under a tenth of this.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
